// ===== src/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg: shared types and constants of the calendar date adder
// Holds the controller states, the command and status records between the
// controller and the datapath, and the month-length lookup.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned IncW   = 16;
  localparam int unsigned StepW  = 1;
  localparam int unsigned RecipW = 13;

  localparam logic [YearW-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YearW-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_APR = 4'd4;
  localparam logic [MonthW-1:0] MONTH_JUN = 4'd6;
  localparam logic [MonthW-1:0] MONTH_SEP = 4'd9;
  localparam logic [MonthW-1:0] MONTH_NOV = 4'd11;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;
  localparam logic [DayW-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DayW-1:0]   DAY_LAST  = 5'd31;

  // Years per century, and its reciprocal scaled by two to the RECIP_SHIFT.
  // The product floors exactly to the century count for every year up to 9999.
  localparam logic [YearW-1:0]  CENTURY     = 14'd100;
  localparam logic [RecipW-1:0] RECIP_100   = 13'd5243;
  localparam int unsigned       RECIP_SHIFT = 19;
  localparam logic [StepW-1:0]  STEP_TOP    = 1'b1;
  localparam logic [6:0]        YMOD_LAST   = 7'd99;

  // Operation codes carried on tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLAMP,
    ST_WALK,
    ST_DONE
  } cda_state_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic clamp;
    logic walk;
    logic out_load;
  } cda_cmd_t;

  typedef struct packed {
    logic div_last;
    logic walk_done;
    logic out_free;
  } cda_status_t;

  function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] month,
                                                    input logic leap);
    logic [DayW-1:0] len;
    case (month) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/cda_ctrl.sv =====
// ----------------------------------------------------------------------------
// cda_ctrl: sequencer of the calendar date adder
// Steps the datapath through the load path (century split, day clamp) or the
// month-by-month walk of an add, then hands the date to the output register.
// ----------------------------------------------------------------------------
module cda_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  input  cda_pkg::cda_status_t status_i,
  output cda_pkg::cda_cmd_t    cmd_o
);
  import cda_pkg::*;

  cda_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_op_i == OP_ADD) ? ST_WALK : ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: state_d = ST_DONE;
      ST_WALK: begin
        if (status_i.walk_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_CLAMP: cmd_o.clamp    = 1'b1;
      ST_WALK:  cmd_o.walk     = 1'b1;
      ST_DONE:  cmd_o.out_load = status_i.out_free;
      default:  cmd_o          = '0;
    endcase
  end

endmodule

// ===== src/cda_dpath.sv =====
// ----------------------------------------------------------------------------
// cda_dpath: date registers and arithmetic of the calendar date adder
// Keeps the current date with the year split into its position within the
// century and the century count modulo four, so the leap test needs no
// division; a load rebuilds the split with a two-step reciprocal multiply.
// ----------------------------------------------------------------------------
module cda_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cda_pkg::cda_cmd_t            cmd_i,
  output cda_pkg::cda_status_t         status_o,
  input  logic                         in_op_i,
  input  logic [cda_pkg::YearW-1:0]    in_year_i,
  input  logic [cda_pkg::MonthW-1:0]   in_month_i,
  input  logic [cda_pkg::DayW-1:0]     in_day_i,
  input  logic [cda_pkg::IncW-1:0]     in_inc_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [cda_pkg::YearW-1:0]    out_year_o,
  output logic [cda_pkg::MonthW-1:0]   out_month_o,
  output logic [cda_pkg::DayW-1:0]     out_day_o,
  output logic                         out_sat_o
);
  import cda_pkg::*;

  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   day_q;
  logic [6:0]        ymod_q;
  logic [1:0]        cmod_q;
  logic [6:0]        quot_q;
  logic [StepW-1:0]  step_q;
  logic [IncW-1:0]   inc_q;
  logic              sat_q;
  logic              out_valid_q;
  logic [YearW-1:0]  out_year_q;
  logic [MonthW-1:0] out_month_q;
  logic [DayW-1:0]   out_day_q;
  logic              out_sat_q;

  logic [YearW-1:0]        year_clamped;
  logic [MonthW-1:0]       month_clamped;
  logic [YearW+RecipW-1:0] recip_prod;
  logic [6:0]              quot_next;
  logic [YearW-1:0]        year_rem;
  logic                    leap;
  logic [DayW-1:0]         month_len;
  logic [IncW:0]           walk_sum;
  logic                    walk_fits;
  logic                    at_limit;
  logic [IncW-1:0]         walk_used;

  always_comb begin
    if (in_year_i < YEAR_MIN) begin
      year_clamped = YEAR_MIN;
    end else if (in_year_i > YEAR_MAX) begin
      year_clamped = YEAR_MAX;
    end else begin
      year_clamped = in_year_i;
    end
    if (in_month_i < MONTH_JAN) begin
      month_clamped = MONTH_JAN;
    end else if (in_month_i > MONTH_DEC) begin
      month_clamped = MONTH_DEC;
    end else begin
      month_clamped = in_month_i;
    end
  end

  // The first step takes the century count, the second the year within it.
  assign recip_prod = year_q * RECIP_100;
  assign quot_next  = recip_prod[RECIP_SHIFT +: 7];
  assign year_rem   = year_q - ({{(YearW - 7){1'b0}}, quot_q} * CENTURY);

  // Divisible by four, and either not a century year or a century divisible by four.
  assign leap      = (year_q[1:0] == 2'd0) && ((ymod_q != 7'd0) || (cmod_q == 2'd0));
  assign month_len = days_in_month(month_q, leap);
  assign walk_sum  = {{(IncW + 1 - DayW){1'b0}}, day_q} + {1'b0, inc_q};
  assign walk_fits = (walk_sum <= {{(IncW + 1 - DayW){1'b0}}, month_len});
  assign at_limit  = (month_q >= MONTH_DEC) && (year_q >= YEAR_MAX);
  assign walk_used = {{(IncW - DayW){1'b0}}, month_len - day_q + DAY_FIRST};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= YEAR_MIN;
      month_q <= MONTH_JAN;
      day_q   <= DAY_FIRST;
      ymod_q  <= 7'd1;
      cmod_q  <= 2'd0;
      step_q  <= '0;
      sat_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      sat_q <= 1'b0;
      if (in_op_i == OP_LOAD) begin
        year_q  <= year_clamped;
        month_q <= month_clamped;
        day_q   <= in_day_i;
        cmod_q  <= 2'd0;
        step_q  <= STEP_TOP;
      end
    end else if (cmd_i.div_step) begin
      if (step_q == 1'b0) begin
        cmod_q <= quot_q[1:0];
        ymod_q <= year_rem[6:0];
      end
      step_q <= step_q - 1'b1;
    end else if (cmd_i.clamp) begin
      if (day_q < DAY_FIRST) begin
        day_q <= DAY_FIRST;
      end else if (day_q > month_len) begin
        day_q <= month_len;
      end
    end else if (cmd_i.walk) begin
      if (walk_fits) begin
        day_q <= walk_sum[DayW-1:0];
      end else if (at_limit) begin
        year_q  <= YEAR_MAX;
        month_q <= MONTH_DEC;
        day_q   <= DAY_LAST;
        sat_q   <= 1'b1;
      end else begin
        day_q <= DAY_FIRST;
        if (month_q >= MONTH_DEC) begin
          month_q <= MONTH_JAN;
          year_q  <= year_q + 14'd1;
          if (ymod_q == YMOD_LAST) begin
            ymod_q <= 7'd0;
            cmod_q <= cmod_q + 2'd1;
          end else begin
            ymod_q <= ymod_q + 7'd1;
          end
        end else begin
          month_q <= month_q + 4'd1;
        end
      end
    end
  end

  // Working registers of the split and the walk carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      inc_q <= in_inc_i;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_next;
    end else if (cmd_i.walk && !walk_fits && !at_limit) begin
      inc_q <= inc_q - walk_used;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_year_q  <= year_q;
      out_month_q <= month_q;
      out_day_q   <= day_q;
      out_sat_q   <= sat_q;
    end
  end

  assign status_o.div_last  = (step_q == 1'b0);
  assign status_o.walk_done = walk_fits || at_limit;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_year_o  = out_year_q;
  assign out_month_o = out_month_q;
  assign out_day_o   = out_day_q;
  assign out_sat_o   = out_sat_q;

endmodule

// ===== src/calendar_date_add_days.sv =====
// ----------------------------------------------------------------------------
// calendar_date_add_days: calendar date register with day addition
// Holds a Gregorian date and either loads a new one or advances it by a
// count of days, returning the resulting date for every input beat.
// ----------------------------------------------------------------------------
// Usage:
// Input beats arrive on the s_axis group; tuser selects a load (0) or an
// add (1). Every input beat produces exactly one output beat on m_axis with
// the date after that operation and a flag that is set when an add ran past
// the last day of year 9999 and the date was held there.
// A load goes from acceptance to the output register in order: two steps
// rebuild the century split of the year with a reciprocal multiply, then the
// day is clamped to the month length. An add walks from the day it holds
// to the end of each month in turn, one month per cycle, until the rest of
// the count fits in the current month; the largest count is 65535 days.
// Only one item is in work at a time: s_axis_tready is high while the
// sequencer is idle. The output register holds a finished result while the
// receiver stalls, and the next input beat is already taken during that
// wait; the following result waits in the sequencer until the register
// drains. Reset sets the date to 0001-01-01 and empties the output.
// ----------------------------------------------------------------------------
module calendar_date_add_days (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // new_year [13:0], new_month [17:14], new_day [22:18], days_to_add [38:23]
  input  logic [39:0] s_axis_tdata,
  // operation [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cur_year [13:0], cur_month [17:14], cur_day [22:18], year_saturated [23]
  output logic [23:0] m_axis_tdata
);
  import cda_pkg::*;

  cda_cmd_t          cmd;
  cda_status_t       status;
  logic [YearW-1:0]  out_year;
  logic [MonthW-1:0] out_month;
  logic [DayW-1:0]   out_day;
  logic              out_sat;

  cda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cda_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_op_i     (s_axis_tuser),
    .in_year_i   (s_axis_tdata[13:0]),
    .in_month_i  (s_axis_tdata[17:14]),
    .in_day_i    (s_axis_tdata[22:18]),
    .in_inc_i    (s_axis_tdata[38:23]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_year_o  (out_year),
    .out_month_o (out_month),
    .out_day_o   (out_day),
    .out_sat_o   (out_sat)
  );

  assign m_axis_tdata = {out_sat, out_day, out_month, out_year};

endmodule

// ===== test/calendar_date_add_days_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_tb: self-checking bench for the calendar date adder
// A queue-fed driver offers load and add beats on the input stream. A monitor
// keeps its own copy of the date, predicts the date after every accepted beat,
// and checks each output beat against the oldest prediction. Both stream
// sides idle at random, the receiver holds off once for a long stretch, and
// the last part of the run goes at full rate.
// ----------------------------------------------------------------------------
module calendar_date_add_days_tb;
  import cda_pkg::*;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned LongStall   = 3000;
  localparam int unsigned DrainCycles = 64;

  typedef struct {
    logic              op;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [IncW-1:0]   days;
  } date_cmd_t;

  typedef struct {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              sat;
  } date_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  date_cmd_t cmd_q[$];
  date_t     expected_dates[$];

  // Date as the bench believes the block holds it.
  logic [YearW-1:0]  cal_year  = YEAR_MIN;
  logic [MonthW-1:0] cal_month = MONTH_JAN;
  logic [DayW-1:0]   cal_day   = DAY_FIRST;

  int unsigned cycle_cnt     = 0;
  int unsigned err_cnt       = 0;
  int unsigned src_gap       = 0;
  int unsigned sink_gap      = 0;
  int unsigned stall_left    = 0;
  bit          stall_request = 1'b0;
  bit          idle_en       = 1'b1;
  bit          in_beat       = 1'b0;

  calendar_date_add_days dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned len;
    if (m == MONTH_FEB) begin
      len = leap_year(y) ? 29 : 28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = 30;
    end else begin
      len = 31;
    end
    return len;
  endfunction

  // Applies one beat to the tracked date and returns the date it leaves.
  function automatic date_t apply_cmd(input date_cmd_t c);
    int unsigned y, m, d, inc, len;
    date_t r;
    r.sat = 1'b0;
    if (c.op == OP_LOAD) begin
      y = c.year;
      m = c.month;
      d = c.day;
      if (y < YEAR_MIN) y = YEAR_MIN;
      if (y > YEAR_MAX) y = YEAR_MAX;
      if (m < MONTH_JAN) m = MONTH_JAN;
      if (m > MONTH_DEC) m = MONTH_DEC;
      len = month_length(y, m);
      if (d < DAY_FIRST) d = DAY_FIRST;
      if (d > len) d = len;
    end else begin
      y   = cal_year;
      m   = cal_month;
      d   = cal_day;
      inc = c.days;
      while (d + inc > month_length(y, m)) begin
        // Leaving December of the last year pins the date and drops the rest.
        if (m >= MONTH_DEC && y >= YEAR_MAX) begin
          y     = YEAR_MAX;
          m     = MONTH_DEC;
          d     = DAY_LAST;
          inc   = 0;
          r.sat = 1'b1;
          break;
        end
        inc -= month_length(y, m) - d + 1;
        d = DAY_FIRST;
        if (m >= MONTH_DEC) begin
          m = MONTH_JAN;
          y++;
        end else begin
          m++;
        end
      end
      d += inc;
    end
    cal_year  = YearW'(y);
    cal_month = MonthW'(m);
    cal_day   = DayW'(d);
    r.year    = YearW'(y);
    r.month   = MonthW'(m);
    r.day     = DayW'(d);
    return r;
  endfunction

  function automatic logic [IncW-1:0] random_days();
    int unsigned pick;
    logic [IncW-1:0] n;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      n = '0;
    end else if (pick <= 2) begin
      n = IncW'($urandom_range(0, 65535));
    end else if (pick <= 7) begin
      n = IncW'($urandom_range(0, 1500));
    end else begin
      n = IncW'($urandom_range(1, 62));
    end
    return n;
  endfunction

  task automatic queue_cmd(input logic op, input int unsigned y, input int unsigned m,
                           input int unsigned d, input int unsigned n);
    date_cmd_t c;
    c.op    = op;
    c.year  = YearW'(y);
    c.month = MonthW'(m);
    c.day   = DayW'(d);
    c.days  = IncW'(n);
    cmd_q.push_back(c);
  endtask

  // Mostly a valid load followed by a few adds; the rest is arbitrary fields.
  task automatic queue_random(input int unsigned n);
    int unsigned left, run, y, m, pick;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 16383), $urandom_range(0, 15),
                  $urandom_range(0, 31), random_days());
        left--;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
          y = $urandom_range(9900, 9999);
        end else if (pick == 3) begin
          y = $urandom_range(1, 400);
        end else begin
          y = $urandom_range(1, 9999);
        end
        m = $urandom_range(1, 12);
        queue_cmd(OP_LOAD, y, m, $urandom_range(1, month_length(y, m)), $urandom_range(0, 65535));
        left--;
        run = $urandom_range(1, 5);
        while (run > 0 && left > 0) begin
          queue_cmd(OP_ADD, $urandom_range(0, 16383), $urandom_range(0, 15),
                    $urandom_range(0, 31), random_days());
          run--;
          left--;
        end
      end
    end
  endtask

  // Monitor: samples both handshakes at the rising edge.
  always @(posedge clk_i) begin
    date_cmd_t c;
    date_t got, want;
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        in_beat = s_axis_tvalid && s_axis_tready;
        if (in_beat) begin
          c.op    = s_axis_tuser;
          c.year  = s_axis_tdata[13:0];
          c.month = s_axis_tdata[17:14];
          c.day   = s_axis_tdata[22:18];
          c.days  = s_axis_tdata[38:23];
          expected_dates.push_back(apply_cmd(c));
        end
        if (m_axis_tvalid && m_axis_tready) begin
          got.year  = m_axis_tdata[13:0];
          got.month = m_axis_tdata[17:14];
          got.day   = m_axis_tdata[22:18];
          got.sat   = m_axis_tdata[23];
          if (expected_dates.size() == 0) begin
            $error("output beat with no date expected: %0d-%0d-%0d",
                   got.year, got.month, got.day);
            err_cnt++;
          end else begin
            want = expected_dates.pop_front();
            if (got.year !== want.year) begin
              $error("cur_year mismatch: expected %0d, got %0d", want.year, got.year);
              err_cnt++;
            end
            if (got.month !== want.month) begin
              $error("cur_month mismatch: expected %0d, got %0d", want.month, got.month);
              err_cnt++;
            end
            if (got.day !== want.day) begin
              $error("cur_day mismatch: expected %0d, got %0d", want.day, got.day);
              err_cnt++;
            end
            if (got.sat !== want.sat) begin
              $error("year_saturated mismatch: expected %0d, got %0d", want.sat, got.sat);
              err_cnt++;
            end
          end
        end
      end
    end
  end

  // Input driver: holds a beat until it is taken, then moves to the next one.
  always @(negedge clk_i) begin
    date_cmd_t c;
    if (rst_ni) begin
      if (s_axis_tvalid && !in_beat) begin
        // The current beat is still waiting for the block.
      end else if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0 && idle_en && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 10);
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, c.days, c.day, c.month, c.year};
        s_axis_tuser  <= c.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left    = LongStall;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    m_axis_tready = 1'b0;

    // Directed beats: reset date, clamping, leap rules, rollovers, saturation.
    queue_cmd(OP_ADD,  0, 0, 0, 0);
    queue_cmd(OP_ADD,  0, 0, 0, 31);
    queue_cmd(OP_LOAD, 0, 0, 0, 0);
    queue_cmd(OP_LOAD, 16383, 15, 31, 0);
    queue_cmd(OP_ADD,  16383, 15, 31, 0);
    queue_cmd(OP_ADD,  0, 0, 0, 1);
    queue_cmd(OP_LOAD, 2000, 2, 31, 0);
    queue_cmd(OP_LOAD, 1900, 2, 30, 0);
    queue_cmd(OP_LOAD, 2024, 2, 29, 0);
    queue_cmd(OP_LOAD, 2023, 4, 31, 0);
    queue_cmd(OP_ADD,  0, 0, 0, 1);
    queue_cmd(OP_LOAD, 2023, 12, 31, 0);
    queue_cmd(OP_ADD,  0, 0, 0, 1);
    queue_cmd(OP_LOAD, 1999, 2, 28, 0);
    queue_cmd(OP_ADD,  0, 0, 0, 1);
    queue_cmd(OP_LOAD, 2000, 2, 28, 0);
    queue_cmd(OP_ADD,  0, 0, 0, 1);
    queue_cmd(OP_LOAD, 1, 1, 1, 65535);
    queue_cmd(OP_ADD,  16383, 15, 31, 65535);
    queue_cmd(OP_ADD,  0, 0, 0, 65535);
    queue_cmd(OP_LOAD, 9999, 1, 1, 0);
    queue_cmd(OP_ADD,  0, 0, 0, 364);
    queue_cmd(OP_LOAD, 9999, 1, 1, 0);
    queue_cmd(OP_ADD,  0, 0, 0, 400);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender pause: nothing new goes in until the directed results are back.
    while (cmd_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);

    queue_random(110);
    while (cmd_q.size() > 60) @(posedge clk_i);
    stall_request = 1'b1;
    queue_random(90);
    while (cmd_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);

    // Closing stretch at full rate on both sides.
    idle_en = 1'b0;
    queue_random(70);
    while (cmd_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cda_pkg.sv
src/cda_ctrl.sv
src/cda_dpath.sv
src/calendar_date_add_days.sv
test/calendar_date_add_days_tb.sv
